[hdl/xact_page_lock_manager_defines.svh]
// Assertion macros shared by the lock manager RTL.
`ifndef XACT_PAGE_LOCK_MANAGER_DEFINES_SVH
`define XACT_PAGE_LOCK_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that a property holds on every clock edge outside reset.
`define XPLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never occurs outside reset.
`define XPLM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define XPLM_ASSERT(lbl, prop, msg)
`define XPLM_NEVER(lbl, cond, msg)
`endif

`endif

[hdl/xplm_pkg.sv]
// Types and constants of the transaction page lock manager.
`default_nettype none

package xplm_pkg;

  localparam int KEY_W = 20;
  localparam int ID_W  = 32;

  localparam logic [1:0] ST_SUCCESS   = 2'd0;
  localparam logic [1:0] ST_RETRY     = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  localparam logic OP_BEGIN  = 1'b0;
  localparam logic OP_COMMIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DECIDE,
    S_INSERT,
    S_FIND,
    S_KREAD,
    S_FREE,
    S_RELEASE,
    S_REPLY
  } state_t;

endpackage

`default_nettype wire

[hdl/xact_page_lock_manager.sv]
// Transaction page lock manager: all-or-nothing page locking under one small sequencer.
// A begin item without last only buffers any page it carries; a closing begin item scans
// the lock store once and, on success, walks it again to insert keys.
// A commit scans the records, then makes one lock store pass per page.
// The lock store's single read port sets the pace; no item is accepted meanwhile.
// Reset (rst_n, synchronous, active low) clears all valid bits and the pending buffer.
`default_nettype none

`include "xact_page_lock_manager_defines.svh"

module xact_page_lock_manager
  import xplm_pkg::*;
#(
  parameter int PAGES_PER_REGION = 1024,
  parameter int LOCK_ENTRIES     = 256,
  parameter int XACT_ENTRIES     = 16,
  parameter int PAGES_PER_XACT   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] xact_id, [41:32] region, [51:42] page_offset, [55:52] zero
  input  wire logic [55:0] in_tdata,
  // [0] op, [1] carries_page
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] reply_xact_id
  output logic [31:0]      out_tdata,
  // [1:0] status
  output logic [1:0]       out_tuser
);

  // Widths derived from the table sizes.
  localparam int LW   = $clog2(LOCK_ENTRIES);
  localparam int LCW  = $clog2(LOCK_ENTRIES + 1);
  localparam int XW   = (XACT_ENTRIES > 1) ? $clog2(XACT_ENTRIES) : 1;
  localparam int PIW  = (PAGES_PER_XACT > 1) ? $clog2(PAGES_PER_XACT) : 1;
  localparam int CW   = $clog2(PAGES_PER_XACT + 1);
  localparam int CMW  = (LCW > CW) ? LCW : CW;
  localparam int PGN  = XACT_ENTRIES * PAGES_PER_XACT;
  localparam int PMW  = (PGN > 1) ? $clog2(PGN) : 1;

  localparam logic [LW:0]    LOCK_N = (LW + 1)'(LOCK_ENTRIES);
  localparam logic [XW:0]    XACT_N = (XW + 1)'(XACT_ENTRIES);
  localparam logic [CW-1:0]  PEND_N = CW'(PAGES_PER_XACT);
  localparam logic [PMW-1:0] PPX_C  = PMW'(PAGES_PER_XACT);
  localparam logic [20:0]    PPR_C  = 21'(PAGES_PER_REGION);

  // Sequencer and scan control.
  state_t state_r, state_nxt;
  logic [LW:0]     scan_r;
  logic            chk_r;
  logic [LW-1:0]   chk_idx_r;
  logic            hit_r;
  logic [LCW-1:0]  free_cnt_r;
  logic [XW:0]     xs_r;
  logic            found_r;
  logic [XW-1:0]   slot_r;
  logic [XW-1:0]   best_age_r;
  logic [CW-1:0]   pi_r;
  logic [CW-1:0]   pg_cnt_r;
  logic [ID_W-1:0] id_r;
  logic [1:0]      st_r;

  // Lock store: keys in a memory, valid bits in flip-flops.
  logic [KEY_W-1:0] lock_mem [LOCK_ENTRIES];
  logic [KEY_W-1:0] lock_rd_r;
  logic             lock_vld_r [LOCK_ENTRIES];

  // Per-transaction page list memory.
  logic [KEY_W-1:0] page_mem [PGN];
  logic [KEY_W-1:0] page_rd_r;

  // Transaction records.
  logic [ID_W-1:0]  xact_id_r  [XACT_ENTRIES];
  logic             xact_vld_r [XACT_ENTRIES];
  logic [XW-1:0]    xact_age_r [XACT_ENTRIES];
  logic [CW-1:0]    xact_cnt_r [XACT_ENTRIES];

  // Pending begin request.
  logic [KEY_W-1:0] pend_key_r [PAGES_PER_XACT];
  logic [CW-1:0]    pend_cnt_r;
  logic             pend_ovf_r;

  // Output register.
  logic             out_vld_r;
  logic [1:0]       out_st_r;
  logic [ID_W-1:0]  out_id_r;

  // Combinational helpers.
  logic             in_acc;
  logic [KEY_W-1:0] in_key;
  logic [20:0]      key_sum;
  logic [LW-1:0]    lock_idx;
  logic             scan_live;
  logic             scan_done;
  logic             pend_hit;
  logic             free_match;
  logic             insert_done;
  logic             ins_take;
  logic [XW-1:0]    xi;
  logic             find_done;
  logic             find_take;
  logic             fs_any;
  logic [XW-1:0]    fs_idx;
  logic             out_free;
  logic             room_ok;
  logic [PMW-1:0]   pg_addr;
  logic [PIW-1:0]   pi_idx;

  assign key_sum   = 21'(in_tdata[41:32]) * PPR_C + 21'(in_tdata[51:42]);
  assign in_key    = key_sum[KEY_W-1:0];
  assign lock_idx  = scan_r[LW-1:0];
  assign scan_live = (scan_r != LOCK_N);
  assign scan_done = !scan_live && !chk_r;
  assign pi_idx    = pi_r[PIW-1:0];
  assign pg_addr   = PMW'(slot_r) * PPX_C + PMW'(pi_r);
  assign xi        = xs_r[XW-1:0];
  assign find_done = (xs_r == XACT_N);
  assign out_free  = !out_vld_r || out_tready;
  assign insert_done = (pi_r == pend_cnt_r);
  assign free_match  = chk_r && lock_vld_r[chk_idx_r] && (lock_rd_r == page_rd_r);
  assign room_ok = !hit_r && !pend_ovf_r && fs_any &&
                   (CMW'(free_cnt_r) >= CMW'(pend_cnt_r));

  // The lock entry read last cycle against every buffered key at once.
  always_comb begin
    pend_hit = 1'b0;
    for (int k = 0; k < PAGES_PER_XACT; k++) begin
      if ((CW'(k) < pend_cnt_r) && (pend_key_r[k] == lock_rd_r)) begin
        pend_hit = 1'b1;
      end
    end
  end

  // Lowest free record slot.
  always_comb begin
    fs_any = 1'b0;
    fs_idx = '0;
    for (int j = XACT_ENTRIES - 1; j >= 0; j--) begin
      if (!xact_vld_r[j]) begin
        fs_any = 1'b1;
        fs_idx = XW'(j);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == OP_COMMIT) begin
            state_nxt = S_FIND;
          end else if (in_tlast) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = room_ok ? S_INSERT : S_REPLY;
      end
      S_INSERT: begin
        if (insert_done) state_nxt = S_REPLY;
      end
      S_FIND: begin
        if (find_done) state_nxt = found_r ? S_KREAD : S_REPLY;
      end
      S_KREAD: begin
        state_nxt = (pi_r == pg_cnt_r) ? S_RELEASE : S_FREE;
      end
      S_FREE: begin
        if (free_match) begin
          state_nxt = S_KREAD;
        end else if (scan_done) begin
          state_nxt = S_REPLY;
        end
      end
      S_RELEASE: begin
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    ins_take  = 1'b0;
    find_take = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_INSERT: begin
        ins_take = !insert_done && scan_live && !lock_vld_r[lock_idx];
      end
      S_FIND: begin
        find_take = !find_done && xact_vld_r[xi] && (xact_id_r[xi] == id_r) &&
                    (!found_r || (xact_age_r[xi] < best_age_r));
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_st_r;

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_cnt_r <= '0;
      pend_ovf_r <= 1'b0;
      for (int e = 0; e < LOCK_ENTRIES; e++) lock_vld_r[e] <= 1'b0;
      for (int j = 0; j < XACT_ENTRIES; j++) xact_vld_r[j] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser[0] == OP_BEGIN && in_tuser[1]) begin
            if (pend_cnt_r < PEND_N) begin
              pend_cnt_r <= pend_cnt_r + CW'(1);
            end else begin
              pend_ovf_r <= 1'b1;
            end
          end
        end
        S_DECIDE: begin
          if (!room_ok) begin
            pend_cnt_r <= '0;
            pend_ovf_r <= 1'b0;
          end
        end
        S_INSERT: begin
          if (insert_done) begin
            pend_cnt_r         <= '0;
            pend_ovf_r         <= 1'b0;
            xact_vld_r[slot_r] <= 1'b1;
          end else if (ins_take) begin
            lock_vld_r[lock_idx] <= 1'b1;
          end
        end
        S_FREE: begin
          if (free_match) lock_vld_r[chk_idx_r] <= 1'b0;
        end
        S_RELEASE: begin
          xact_vld_r[slot_r] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result valid: set as the reply state hands over, cleared once the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((state_r == S_REPLY) && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        scan_r     <= '0;
        chk_r      <= 1'b0;
        hit_r      <= 1'b0;
        free_cnt_r <= '0;
        xs_r       <= '0;
        found_r    <= 1'b0;
        pi_r       <= '0;
        if (in_acc) id_r <= in_tdata[31:0];
        if (in_acc && in_tuser[0] == OP_BEGIN && in_tuser[1] && pend_cnt_r < PEND_N) begin
          pend_key_r[pend_cnt_r[PIW-1:0]] <= in_key;
        end
      end
      S_CHECK: begin
        chk_r     <= scan_live;
        chk_idx_r <= lock_idx;
        if (scan_live) scan_r <= scan_r + (LW + 1)'(1);
        if (chk_r) begin
          if (lock_vld_r[chk_idx_r]) begin
            if (pend_hit) hit_r <= 1'b1;
          end else begin
            free_cnt_r <= free_cnt_r + LCW'(1);
          end
        end
      end
      S_DECIDE: begin
        slot_r <= fs_idx;
        scan_r <= '0;
        pi_r   <= '0;
        st_r   <= hit_r ? ST_RETRY : ST_NO_MEMORY;
      end
      S_INSERT: begin
        if (insert_done) begin
          for (int j = 0; j < XACT_ENTRIES; j++) begin
            if (xact_vld_r[j]) xact_age_r[j] <= xact_age_r[j] + XW'(1);
          end
          xact_age_r[slot_r] <= '0;
          xact_id_r[slot_r]  <= id_r;
          xact_cnt_r[slot_r] <= pend_cnt_r;
          st_r               <= ST_SUCCESS;
        end else begin
          if (scan_live) scan_r <= scan_r + (LW + 1)'(1);
          if (ins_take) pi_r <= pi_r + CW'(1);
        end
      end
      S_FIND: begin
        if (!find_done) begin
          xs_r <= xs_r + (XW + 1)'(1);
          if (find_take) begin
            found_r    <= 1'b1;
            slot_r     <= xi;
            best_age_r <= xact_age_r[xi];
          end
        end else begin
          pg_cnt_r <= xact_cnt_r[slot_r];
          st_r     <= ST_INVALID;
        end
      end
      S_KREAD: begin
        scan_r <= '0;
        chk_r  <= 1'b0;
        st_r   <= ST_SUCCESS;
      end
      S_FREE: begin
        chk_r     <= scan_live;
        chk_idx_r <= lock_idx;
        if (scan_live) scan_r <= scan_r + (LW + 1)'(1);
        if (free_match) begin
          pi_r <= pi_r + CW'(1);
        end else if (scan_done) begin
          st_r <= ST_INVALID;
        end
      end
      S_RELEASE: begin
        for (int j = 0; j < XACT_ENTRIES; j++) begin
          if (xact_vld_r[j] && xact_age_r[j] > best_age_r) begin
            xact_age_r[j] <= xact_age_r[j] - XW'(1);
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_st_r <= st_r;
          out_id_r <= id_r;
        end
      end
      default: begin
        chk_r <= 1'b0;
      end
    endcase
  end

  // Lock key memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (ins_take) lock_mem[lock_idx] <= pend_key_r[pi_idx];
    lock_rd_r <= lock_mem[lock_idx];
  end

  // Page list memory.
  always_ff @(posedge clk) begin
    if (ins_take) page_mem[pg_addr] <= pend_key_r[pi_idx];
    page_rd_r <= page_mem[pg_addr];
  end

  `XPLM_NEVER(a_pend_bound, pend_cnt_r > PEND_N, "pending page count beyond buffer size")
  `XPLM_NEVER(a_ins_room, (state_r == S_INSERT) && !insert_done && !scan_live, "insert ran out of lock entries")
  `XPLM_ASSERT(a_release, (state_r == S_RELEASE) |=> !xact_vld_r[slot_r], "released record still valid")
  `XPLM_ASSERT(a_reply, (state_r == S_REPLY) && out_free |=> out_vld_r, "reply not presented")

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the transaction page lock manager.
`default_nettype none

module tb_top;
  import xplm_pkg::*;

  localparam int LOCK_N   = 256;
  localparam int XACT_N   = 16;
  localparam int PAGE_MAX = 16;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic        op;
    logic [31:0] xact_id;
    logic [9:0]  region;
    logic [9:0]  page_offset;
    logic        carries_page;
    logic        last;
  } lock_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] xact_id;
  } lock_reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  xact_page_lock_manager DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Shadow copy of the block's state, updated as requests are accepted.
  logic [19:0] lk_key [LOCK_N];
  logic        lk_vld [LOCK_N];
  logic [31:0] tx_id  [XACT_N];
  logic        tx_vld [XACT_N];
  int          tx_age [XACT_N];
  logic [19:0] tx_keys[XACT_N][PAGE_MAX];
  int          tx_cnt [XACT_N];
  logic [19:0] pend_keys[PAGE_MAX];
  int          pend_cnt;
  logic        pend_ovf;

  lock_req_t   req_queue[$];
  lock_reply_t reply_queue[$];

  int  idle_in_pct, idle_out_pct;
  bit  stim_done;
  bit  failed;
  int  cycles;

  function automatic int lock_find(logic [19:0] key);
    for (int i = 0; i < LOCK_N; i++)
      if (lk_vld[i] && lk_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int free_lock_count();
    int n;
    n = 0;
    for (int i = 0; i < LOCK_N; i++) if (!lk_vld[i]) n++;
    return n;
  endfunction

  // Grant or refuse the whole buffered request, all or nothing.
  function automatic logic [1:0] grant_pages(logic [31:0] id);
    int slot;
    slot = -1;
    for (int i = 0; i < pend_cnt; i++)
      if (lock_find(pend_keys[i]) >= 0) return ST_RETRY;
    for (int j = XACT_N - 1; j >= 0; j--) if (!tx_vld[j]) slot = j;
    if (pend_ovf || slot < 0 || free_lock_count() < pend_cnt) return ST_NO_MEMORY;
    for (int i = 0; i < pend_cnt; i++) begin
      for (int e = 0; e < LOCK_N; e++)
        if (!lk_vld[e]) begin
          lk_vld[e] = 1'b1;
          lk_key[e] = pend_keys[i];
          break;
        end
      tx_keys[slot][i] = pend_keys[i];
    end
    for (int j = 0; j < XACT_N; j++) if (tx_vld[j]) tx_age[j]++;
    tx_id[slot] = id;
    tx_vld[slot] = 1'b1;
    tx_age[slot] = 0;
    tx_cnt[slot] = pend_cnt;
    return ST_SUCCESS;
  endfunction

  // Release the newest record with this id.
  function automatic logic [1:0] release_pages(logic [31:0] id);
    int slot, e, age;
    slot = -1;
    for (int j = 0; j < XACT_N; j++)
      if (tx_vld[j] && tx_id[j] == id && (slot < 0 || tx_age[j] < tx_age[slot]))
        slot = j;
    if (slot < 0) return ST_INVALID;
    for (int i = 0; i < tx_cnt[slot]; i++) begin
      e = lock_find(tx_keys[slot][i]);
      if (e < 0) return ST_INVALID;
      lk_vld[e] = 1'b0;
    end
    age = tx_age[slot];
    tx_vld[slot] = 1'b0;
    for (int j = 0; j < XACT_N; j++) if (tx_vld[j] && tx_age[j] > age) tx_age[j]--;
    return ST_SUCCESS;
  endfunction

  // Apply one accepted request to the shadow state and queue any expected reply.
  task automatic predict_request(lock_req_t r);
    lock_reply_t rep;
    if (r.op == OP_COMMIT) begin
      rep.status = release_pages(r.xact_id);
    end else begin
      if (r.carries_page) begin
        if (pend_cnt < PAGE_MAX) begin
          pend_keys[pend_cnt] = {r.region, r.page_offset};
          pend_cnt++;
        end else begin
          pend_ovf = 1'b1;
        end
      end
      if (!r.last) return;
      rep.status = grant_pages(r.xact_id);
      pend_cnt = 0;
      pend_ovf = 1'b0;
    end
    rep.xact_id = r.xact_id;
    reply_queue.push_back(rep);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: presents queued requests, idling at random between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (req_queue.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
        lock_req_t r;
        r = req_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'd0, r.page_offset, r.region, r.xact_id};
        in_tuser  <= {r.carries_page, r.op};
        in_tlast  <= r.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The prediction runs at acceptance, so it sees the state in request order.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      lock_req_t r;
      r.op           = in_tuser[0];
      r.carries_page = in_tuser[1];
      r.xact_id      = in_tdata[31:0];
      r.region       = in_tdata[41:32];
      r.page_offset  = in_tdata[51:42];
      r.last         = in_tlast;
      predict_request(r);
    end
  end

  // Monitor: back-pressure at random and compare each reply with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: unexpected reply status=%0d id=%h", $time, out_tuser, out_tdata);
          failed = 1'b1;
        end else begin
          lock_reply_t x;
          x = reply_queue.pop_front();
          if (x.status !== out_tuser) begin
            $display("%0t: status expected %0d actual %0d", $time, x.status, out_tuser);
            failed = 1'b1;
          end
          if (x.xact_id !== out_tdata) begin
            $display("%0t: reply id expected %h actual %h", $time, x.xact_id, out_tdata);
            failed = 1'b1;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("xact_page_lock_manager verification failed");
      $finish;
    end
  end

  function automatic lock_req_t page_req(logic [31:0] id, logic [9:0] rg, logic [9:0] off,
                                         logic carry, logic lst);
    lock_req_t r;
    r.op = OP_BEGIN; r.xact_id = id; r.region = rg; r.page_offset = off;
    r.carries_page = carry; r.last = lst;
    return r;
  endfunction

  function automatic lock_req_t commit_req(logic [31:0] id);
    lock_req_t r;
    r.op = OP_COMMIT; r.xact_id = id;
    r.region = 10'($urandom); r.page_offset = 10'($urandom);
    r.carries_page = 1'($urandom); r.last = 1'($urandom);
    return r;
  endfunction

  // Small pool of ids so that commits usually find a record.
  function automatic logic [31:0] pick_id();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($urandom_range(7));
    endcase
  endfunction

  // Pages drawn mostly from a narrow key range so that conflicts occur.
  task automatic queue_begin(int npages, logic [31:0] id);
    for (int i = 0; i < npages; i++) begin
      if ($urandom_range(9) == 0)
        req_queue.push_back(page_req(id, 10'($urandom), 10'($urandom), 1'b1,
                                     i == npages - 1));
      else
        req_queue.push_back(page_req(id, 10'($urandom_range(1)), 10'($urandom_range(40)),
                                     1'($urandom_range(7) != 0), i == npages - 1));
    end
  endtask

  task automatic wait_drained();
    while (req_queue.size() > 0 || in_tvalid || reply_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    int phase_items;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    failed = 1'b0;
    cycles = 0;
    stim_done = 1'b0;
    idle_in_pct = 19;
    idle_out_pct = 65;
    pend_cnt = 0;
    pend_ovf = 1'b0;
    for (int i = 0; i < LOCK_N; i++) lk_vld[i] = 1'b0;
    for (int j = 0; j < XACT_N; j++) tx_vld[j] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, empty request, duplicates, conflict, overflow, commits.
    req_queue.push_back(page_req(32'h8000_0000, 10'h3ff, 10'h3ff, 1'b1, 1'b0));
    req_queue.push_back(page_req(32'h0, 10'h0, 10'h0, 1'b1, 1'b1));
    req_queue.push_back(page_req(32'h7fff_ffff, 10'h0, 10'h0, 1'b0, 1'b1));
    req_queue.push_back(page_req(32'h5, 10'h0, 10'h0, 1'b1, 1'b1));
    req_queue.push_back(page_req(32'h6, 10'h155, 10'h2aa, 1'b1, 1'b0));
    req_queue.push_back(page_req(32'h6, 10'h155, 10'h2aa, 1'b1, 1'b1));
    req_queue.push_back(commit_req(32'h9));
    req_queue.push_back(commit_req(32'h0));
    req_queue.push_back(commit_req(32'h0));
    req_queue.push_back(commit_req(32'h6));
    req_queue.push_back(commit_req(32'h7fff_ffff));
    for (int i = 0; i < 17; i++)
      req_queue.push_back(page_req(32'hffff_ffff, 10'h2aa, 10'(i), 1'b1, i == 16));
    req_queue.push_back(page_req(32'h8000_0000, 10'h0, 10'h1, 1'b1, 1'b1));
    req_queue.push_back(commit_req(32'h8000_0000));
    wait_drained();

    // Random: three idling profiles with well-formed requests and some noise.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin idle_in_pct = 65; idle_out_pct = 19; end
      if (ph == 2) begin idle_in_pct = 0;  idle_out_pct = 0;  end
      phase_items = 0;
      while (phase_items < 160) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            int n;
            n = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 5);
            queue_begin(n, pick_id());
            phase_items += n;
          end
          4, 5, 6, 7: begin
            req_queue.push_back(commit_req(pick_id()));
            phase_items++;
          end
          8: begin
            // Many records without commits push the tables towards full.
            int m;
            for (int k = 0; k < 4; k++) begin
              m = $urandom_range(1, 16);
              queue_begin(m, pick_id());
              phase_items += m;
            end
          end
          default: begin
            // Commit landing inside a partly buffered request.
            logic [31:0] id;
            id = pick_id();
            req_queue.push_back(page_req(id, 10'($urandom), 10'($urandom), 1'b1, 1'b0));
            req_queue.push_back(commit_req(pick_id()));
            req_queue.push_back(page_req(id, 10'($urandom), 10'($urandom), 1'($urandom), 1'b1));
            phase_items += 3;
          end
        endcase
        wait_drained();
      end
    end

    wait_drained();
    repeat (600) @(posedge clk);
    if (!failed && reply_queue.size() == 0) begin
      $display("xact_page_lock_manager verification clean");
    end else begin
      $display("xact_page_lock_manager verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/xplm_pkg.sv
hdl/xact_page_lock_manager.sv
sim/tb_top.sv
